// ===== sv/lszr_pkg.sv =====
// Shared types, constants and codes for the light sensor zone ranger.
// No dependencies; imported by every module of the block.
package lszr_pkg;

	localparam int ZONES_DEF = 16;

	localparam int DIV_STEPS = 14;
	localparam logic [13:0] LUX_F_LOW = 14'd625;
	localparam logic [13:0] LUX_F_HIGH = 14'd10000;
	// ceil(2^36 / 100); floor(x*RECIP >> 36) == x / 100 for x < 2^30
	localparam logic [29:0] RECIP_100 = 30'd687194768;
	localparam int RECIP_SHIFT = 36;

	typedef enum logic [1:0] {
		ACT_LOAD_LOW  = 2'd0,
		ACT_LOAD_HIGH = 2'd1,
		ACT_EVENT     = 2'd2,
		ACT_NONE      = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		CFG_LOW_COUNT  = 3'd0,
		CFG_HIGH_COUNT = 3'd1,
		CFG_PROX_THR   = 3'd2,
		CFG_LENS       = 3'd3,
		CFG_TRIGGER    = 3'd4
	} cfg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_MUL,
		ST_SCALE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [3:0]  zone_index;
		logic [7:0]  zone_low_byte;
		logic [7:0]  zone_mid_byte;
		logic [7:0]  zone_high_byte;
		logic        prox_flag;
		logic        als_flag;
		logic [15:0] light_count;
		logic [7:0]  prox_count;
	} in_item_t;

	typedef struct packed {
		logic        prox_valid;
		logic        prox_near;
		logic        lux_valid;
		logic [22:0] lux_value;
		logic        window_update;
		logic [7:0]  window_low_byte;
		logic [7:0]  window_mid_byte;
		logic [7:0]  window_high_byte;
		logic        low_range;
	} out_item_t;

	typedef struct packed {
		logic load_low;
		logic load_high;
		logic start;
		logic run;
		logic mul;
		logic scale;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic run_done;
		logic out_free;
	} status_t;

endpackage

// ===== sv/lszr_ctrl.sv =====
// Sequencer for the zone ranger: decodes accepted items and steps an event
// through scan/divide, multiply, scale and result load. Uses lszr_pkg.
module lszr_ctrl
	import lszr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [1:0]  action,
	output logic        in_ready,
	input  status_t     status,
	output cmd_t        cmd
);

	state_t state_q, state_d;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && action == ACT_EVENT) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (status.run_done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL:   state_d = ST_SCALE;
			ST_SCALE: state_d = ST_OUT;
			ST_OUT: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load_low  = accept && action == ACT_LOAD_LOW;
				cmd.load_high = accept && action == ACT_LOAD_HIGH;
				cmd.start     = accept && action == ACT_EVENT;
			end
			ST_RUN:   cmd.run = 1'b1;
			ST_MUL:   cmd.mul = 1'b1;
			ST_SCALE: cmd.scale = 1'b1;
			ST_OUT:   cmd.load_out = status.out_free;
			default:  cmd = '0;
		endcase
	end

endmodule

// ===== sv/lszr_dp.sv =====
// Datapath of the zone ranger: config registers, zone tables, zone scan,
// lens divider, lux multiply/scale and the result register. Uses lszr_pkg.
module lszr_dp
	import lszr_pkg::*;
#(
	parameter int ZONES = ZONES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output status_t     status,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  in_item_t    in_item,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_item
);

	localparam int AW = (ZONES > 1) ? $clog2(ZONES) : 1;
	localparam logic [8:0] ZONES_W = 9'(ZONES);

	// config
	logic [4:0]  low_count_q, high_count_q;
	logic [7:0]  prox_thr_q, lens_q;
	logic [15:0] trigger_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_count_q  <= '0;
			high_count_q <= '0;
			prox_thr_q   <= '0;
			lens_q       <= '0;
			trigger_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LOW_COUNT:  low_count_q  <= cfg_data[4:0];
				CFG_HIGH_COUNT: high_count_q <= cfg_data[4:0];
				CFG_PROX_THR:   prox_thr_q   <= cfg_data[7:0];
				CFG_LENS:       lens_q       <= cfg_data[7:0];
				CFG_TRIGGER:    trigger_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// zone tables
	logic [23:0] low_tab [ZONES];
	logic [23:0] high_tab [ZONES];
	logic [23:0] low_rd_s1, high_rd_s1;
	logic [23:0] wr_entry;
	logic        wr_ok;
	logic [AW-1:0] wr_addr, rd_addr;
	logic        issue;

	assign wr_entry = {in_item.zone_high_byte, in_item.zone_mid_byte, in_item.zone_low_byte};
	assign wr_ok = {5'd0, in_item.zone_index} < ZONES_W;
	assign wr_addr = AW'(in_item.zone_index);

	always_ff @(posedge clk) begin
		if (cmd.load_low && wr_ok) begin
			low_tab[wr_addr] <= wr_entry;
		end
		if (cmd.load_high && wr_ok) begin
			high_tab[wr_addr] <= wr_entry;
		end
		if (issue) begin
			low_rd_s1  <= low_tab[rd_addr];
			high_rd_s1 <= high_tab[rd_addr];
		end
	end

	// event state and latched fields
	logic        low_mode_q, near_sticky_q;
	logic        in_low_q, als_q, pv_q, pn_q;
	logic [15:0] light_q;
	logic [4:0]  n_q, scan_cnt_q, ri_s1;
	logic        rv_s1;
	logic        wu_q;
	logic [23:0] wsel_q;
	logic [3:0]  div_cnt_q;
	logic [13:0] dvd_q;
	logic [7:0]  rem_q;

	logic        pv, pn, lm_next;
	logic [4:0]  cnt_sel, n_clamped;
	logic [23:0] entry;
	logic [11:0] lo_b, hi_b;
	logic        match;
	logic [8:0]  trial_src, trial;
	logic        div_busy;

	assign pv = in_item.prox_flag || near_sticky_q;
	assign pn = pv && (in_item.prox_count > prox_thr_q);
	assign lm_next = low_mode_q || (in_item.light_count < trigger_q);
	assign cnt_sel = lm_next ? low_count_q : high_count_q;
	assign n_clamped = ({4'd0, cnt_sel} > ZONES_W) ? 5'(ZONES) : cnt_sel;

	assign issue = cmd.run && (scan_cnt_q < n_q);
	assign rd_addr = AW'(scan_cnt_q);

	// lower = b0 | b1[3:0] << 8, upper = b1[7:4] | b2 << 4
	assign entry = in_low_q ? low_rd_s1 : high_rd_s1;
	assign lo_b = entry[11:0];
	assign hi_b = {entry[23:16], entry[15:12]};
	assign match = (light_q >= {4'd0, lo_b}) && (light_q <= {4'd0, hi_b});

	assign trial_src = {rem_q, dvd_q[13]};
	assign trial = trial_src - {1'b0, lens_q};
	assign div_busy = div_cnt_q != 4'(DIV_STEPS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_mode_q    <= 1'b0;
			near_sticky_q <= 1'b0;
			n_q           <= '0;
			scan_cnt_q    <= '0;
			rv_s1         <= 1'b0;
			div_cnt_q     <= 4'(DIV_STEPS);
		end else begin
			if (cmd.start) begin
				if (pv) begin
					near_sticky_q <= pn;
				end
				if (in_item.als_flag) begin
					low_mode_q <= lm_next;
				end
				n_q        <= in_item.als_flag ? n_clamped : 5'd0;
				scan_cnt_q <= '0;
				div_cnt_q  <= '0;
				rv_s1      <= 1'b0;
			end else if (cmd.run) begin
				rv_s1 <= issue;
				if (issue) begin
					scan_cnt_q <= scan_cnt_q + 5'd1;
				end
				if (div_busy) begin
					div_cnt_q <= div_cnt_q + 4'd1;
				end
				// a match in the last low zone leaves low range
				if (rv_s1 && match && in_low_q && ri_s1 == n_q - 5'd1) begin
					low_mode_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			in_low_q <= in_item.als_flag ? lm_next : low_mode_q;
			als_q    <= in_item.als_flag;
			pv_q     <= pv;
			pn_q     <= pn;
			light_q  <= in_item.light_count;
			wu_q     <= 1'b0;
			wsel_q   <= '0;
			dvd_q    <= (in_item.als_flag && lm_next) ? LUX_F_LOW : LUX_F_HIGH;
			rem_q    <= '0;
		end else if (cmd.run) begin
			ri_s1 <= scan_cnt_q;
			if (rv_s1 && match) begin
				wu_q   <= 1'b1;
				wsel_q <= entry;
			end
			if (div_busy) begin
				if (!trial[8]) begin
					rem_q <= trial[7:0];
					dvd_q <= {dvd_q[12:0], 1'b1};
				end else begin
					rem_q <= trial_src[7:0];
					dvd_q <= {dvd_q[12:0], 1'b0};
				end
			end
		end
	end

	assign status.run_done = (scan_cnt_q == n_q) && !rv_s1 && !div_busy;

	// lux = quotient * light / 100, the /100 as a reciprocal multiply
	logic [29:0] prod_s2;
	logic [59:0] scaled;
	logic [22:0] lux_s3;

	assign scaled = {30'd0, prod_s2} * {30'd0, RECIP_100};

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_s2 <= {16'd0, dvd_q} * {14'd0, light_q};
		end
		if (cmd.scale) begin
			lux_s3 <= scaled[RECIP_SHIFT+22:RECIP_SHIFT];
		end
	end

	// result register
	logic out_valid_q;
	out_item_t out_q;

	assign status.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.prox_valid       <= pv_q;
			out_q.prox_near        <= pn_q;
			out_q.lux_valid        <= als_q;
			out_q.lux_value        <= (als_q && lens_q != 8'd0) ? lux_s3 : 23'd0;
			out_q.window_update    <= wu_q;
			out_q.window_low_byte  <= wsel_q[7:0];
			out_q.window_mid_byte  <= wsel_q[15:8];
			out_q.window_high_byte <= wsel_q[23:16];
			out_q.low_range        <= low_mode_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_q;

endmodule

// ===== sv/light_sensor_zone_ranger_unit.sv =====
// Light sensor zone ranger, top level: stream ports and config port.
// Sequence: a load item gives no result; an event item gives its result after the
// 14-step lens divider, running beside the one-zone-per-cycle table scan of at most
// ZONES zones, then a multiply, a scale and a result load that waits for a free output.
// Throughput: one event at a time; loads every cycle while no event is in progress.
// Reset (arst_n low) clears range and proximity state and all config registers;
// zone tables are undefined until loaded. Depends on lszr_pkg, lszr_ctrl, lszr_dp.
module light_sensor_zone_ranger_unit
	import lszr_pkg::*;
#(
	parameter int ZONES = ZONES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// zone_index, zone_low_byte, zone_mid_byte, zone_high_byte, prox_flag,
	// als_flag, light_count, prox_count, zero pad
	input  logic [55:0] s_tdata,
	// action
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// prox_near, lux_value, window_low_byte, window_mid_byte, window_high_byte,
	// low_range, zero pad
	output logic [55:0] m_tdata,
	// prox_valid, lux_valid, window_update
	output logic [2:0]  m_tuser,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	in_item_t  in_item;
	out_item_t out_item;
	cmd_t      cmd;
	status_t   status;

	assign in_item.zone_index     = s_tdata[3:0];
	assign in_item.zone_low_byte  = s_tdata[11:4];
	assign in_item.zone_mid_byte  = s_tdata[19:12];
	assign in_item.zone_high_byte = s_tdata[27:20];
	assign in_item.prox_flag      = s_tdata[28];
	assign in_item.als_flag       = s_tdata[29];
	assign in_item.light_count    = s_tdata[45:30];
	assign in_item.prox_count     = s_tdata[53:46];

	lszr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.action   (s_tuser),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	lszr_dp #(
		.ZONES (ZONES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_item   (in_item),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_item  (out_item)
	);

	assign m_tdata = {7'd0, out_item.low_range, out_item.window_high_byte,
		out_item.window_mid_byte, out_item.window_low_byte, out_item.lux_value,
		out_item.prox_near};
	assign m_tuser = {out_item.window_update, out_item.lux_valid, out_item.prox_valid};

	// loads never stall the input side
	a_load_keeps_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == ACT_LOAD_LOW || s_tuser == ACT_LOAD_HIGH)
		|=> s_tready)
		else $error("input stalled after a zone load");

	// an event holds off further items while it is worked on
	a_event_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == ACT_EVENT |=> !s_tready)
		else $error("input taken while an event is in progress");

	// a new result is only loaded while an event is in progress
	a_result_from_event: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared without an event in progress");

endmodule

// ===== tb/light_sensor_zone_ranger_unit_tb.sv =====
// Testbench for light_sensor_zone_ranger_unit: directed and random stream traffic,
// checked against an in-bench predictor of the zone scan, range and lux logic.
// Depends on lszr_pkg and the light_sensor_zone_ranger_unit RTL.
`timescale 1ns / 100ps

module light_sensor_zone_ranger_unit_tb;
	import lszr_pkg::*;

	localparam int NZ = ZONES_DEF;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		action_t     act;
		logic [3:0]  idx;
		logic [7:0]  b0;
		logic [7:0]  b1;
		logic [7:0]  b2;
		logic        pflag;
		logic        aflag;
		logic [15:0] light;
		logic [7:0]  pcount;
	} sensor_item_t;

	typedef struct packed {
		logic        pv;
		logic        pn;
		logic        lv;
		logic [22:0] lux;
		logic        wu;
		logic [7:0]  wl;
		logic [7:0]  wm;
		logic [7:0]  wh;
		logic        lr;
	} ranger_report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// predictor copy of block state and registers
	logic        range_low = 1'b0;
	logic        near_latched = 1'b0;
	logic [23:0] low_zones [NZ];
	logic [23:0] high_zones [NZ];
	logic [4:0]  reg_low_cnt = '0;
	logic [4:0]  reg_high_cnt = '0;
	logic [7:0]  reg_prox_thr = '0;
	logic [7:0]  reg_lens = '0;
	logic [15:0] reg_trigger = '0;

	ranger_report_t expected_reports [$];
	int failures = 0;
	int cycles = 0;
	bit steady = 1'b0;

	light_sensor_zone_ranger_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(0, 99) >= 20);
	end

	function automatic logic [55:0] pack_item(input sensor_item_t it);
		return {2'b00, it.pcount, it.light, it.aflag, it.pflag, it.b2, it.b1, it.b0, it.idx};
	endfunction

	function automatic logic [23:0] make_zone(input logic [11:0] lo, input logic [11:0] hi);
		return {hi[11:4], hi[3:0], lo[11:8], lo[7:0]};
	endfunction

	function automatic logic [11:0] zone_lower(input logic [23:0] e);
		return {e[11:8], e[7:0]};
	endfunction

	function automatic logic [11:0] zone_upper(input logic [23:0] e);
		return {e[23:16], e[15:12]};
	endfunction

	function automatic int clamp_zones(input logic [4:0] cnt);
		return (cnt > NZ) ? NZ : int'(cnt);
	endfunction

	function automatic string report_text(input ranger_report_t r);
		return $sformatf("prox %0d/%0d lux %0d/%0d win %0d %h %h %h low %0d",
			r.pv, r.pn, r.lv, r.lux, r.wu, r.wl, r.wm, r.wh, r.lr);
	endfunction

	// Applies one accepted item to the shadow state; events queue one report.
	function automatic void predict_ranger(input sensor_item_t it);
		ranger_report_t r;
		logic [23:0] e;
		logic [23:0] sel;
		bit in_low;
		int n;
		int unsigned factor;
		int unsigned lux;
		r = '0;
		sel = '0;
		lux = 0;
		case (it.act)
			ACT_LOAD_LOW: low_zones[it.idx] = {it.b2, it.b1, it.b0};
			ACT_LOAD_HIGH: high_zones[it.idx] = {it.b2, it.b1, it.b0};
			ACT_EVENT: begin
				if (it.pflag || near_latched) begin
					r.pv = 1'b1;
					r.pn = it.pcount > reg_prox_thr;
					near_latched = r.pn;
				end
				if (it.aflag) begin
					if (it.light < reg_trigger && !range_low)
						range_low = 1'b1;
					in_low = range_low;
					n = clamp_zones(in_low ? reg_low_cnt : reg_high_cnt);
					for (int i = 0; i < n; i++) begin
						e = in_low ? low_zones[4'(i)] : high_zones[4'(i)];
						if (it.light >= zone_lower(e) && it.light <= zone_upper(e)) begin
							r.wu = 1'b1;
							sel = e;
							// hit in the last low zone drops back to bright range
							if (in_low && i == n - 1)
								range_low = 1'b0;
						end
					end
					r.lv = 1'b1;
					factor = in_low ? 625 : 10000;
					if (reg_lens != 0)
						lux = ((factor / reg_lens) * it.light) / 100;
					r.lux = lux[22:0];
				end
				r.wl = sel[7:0];
				r.wm = sel[15:8];
				r.wh = sel[23:16];
				r.lr = range_low;
				expected_reports.push_back(r);
			end
			default: ;
		endcase
	endfunction

	always @(posedge clk) begin
		ranger_report_t got;
		ranger_report_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.pv = m_tuser[0];
			got.lv = m_tuser[1];
			got.wu = m_tuser[2];
			got.pn = m_tdata[0];
			got.lux = m_tdata[23:1];
			got.wl = m_tdata[31:24];
			got.wm = m_tdata[39:32];
			got.wh = m_tdata[47:40];
			got.lr = m_tdata[48];
			if (expected_reports.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected item: %s", report_text(got));
			end else begin
				want = expected_reports.pop_front();
				if (got !== want) begin
					failures++;
					if (failures <= 10)
						$display("mismatch at cycle %0d\n  expected %s\n  actual   %s",
							cycles, report_text(want), report_text(got));
				end
			end
		end
	end

	task automatic send_item(input sensor_item_t it);
		while (!steady && $urandom_range(0, 99) < 20) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= pack_item(it);
		s_tuser <= it.act;
		do @(posedge clk); while (!s_tready);
		predict_ranger(it);
	endtask

	task automatic drain(input int extra);
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_reports.size() != 0);
		repeat (extra) @(posedge clk);
	endtask

	task automatic reg_write(input cfg_index_t idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic write_config(input logic [4:0] nlow, input logic [4:0] nhigh,
			input logic [7:0] thr, input logic [7:0] lens, input logic [15:0] trig);
		reg_write(CFG_LOW_COUNT, {11'd0, nlow});
		reg_write(CFG_HIGH_COUNT, {11'd0, nhigh});
		reg_write(CFG_PROX_THR, {8'd0, thr});
		reg_write(CFG_LENS, {8'd0, lens});
		reg_write(CFG_TRIGGER, trig);
		cfg_we <= 1'b0;
		reg_low_cnt = nlow;
		reg_high_cnt = nhigh;
		reg_prox_thr = thr;
		reg_lens = lens;
		reg_trigger = trig;
	endtask

	function automatic sensor_item_t event_item(input logic pflag, input logic aflag,
			input logic [15:0] light, input logic [7:0] pcount);
		sensor_item_t it;
		it.act = ACT_EVENT;
		it.idx = 4'($urandom_range(0, 15));
		it.b0 = 8'($urandom_range(0, 255));
		it.b1 = 8'($urandom_range(0, 255));
		it.b2 = 8'($urandom_range(0, 255));
		it.pflag = pflag;
		it.aflag = aflag;
		it.light = light;
		it.pcount = pcount;
		return it;
	endfunction

	function automatic sensor_item_t load_item(input action_t act, input logic [3:0] idx,
			input logic [23:0] entry);
		sensor_item_t it;
		it = event_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
		it.act = act;
		it.idx = idx;
		{it.b2, it.b1, it.b0} = entry;
		return it;
	endfunction

	function automatic logic [15:0] light_in_zone(input logic [23:0] e);
		if (zone_lower(e) <= zone_upper(e))
			return 16'($urandom_range(zone_upper(e), zone_lower(e)));
		return {4'd0, zone_lower(e)};
	endfunction

	// Mostly lights that land in or at the edge of a loaded window.
	function automatic sensor_item_t random_event();
		logic [23:0] e;
		logic [15:0] light;
		logic [7:0] pcount;
		int r;
		int n;
		r = $urandom_range(0, 99);
		e = (range_low || $urandom_range(0, 1)) ? low_zones[4'($urandom_range(0, NZ - 1))]
			: high_zones[4'($urandom_range(0, NZ - 1))];
		n = clamp_zones(reg_low_cnt);
		if (r < 45)
			light = light_in_zone(e);
		else if (r < 60) begin
			case ($urandom_range(0, 3))
				0: light = {4'd0, zone_lower(e)};
				1: light = {4'd0, zone_upper(e)};
				2: light = zone_lower(e) - 16'd1;
				default: light = zone_upper(e) + 16'd1;
			endcase
		end else if (r < 75 && n > 0)
			light = light_in_zone(low_zones[4'(n - 1)]);
		else
			light = 16'($urandom_range(0, 65535));
		case ($urandom_range(0, 3))
			0: pcount = reg_prox_thr;
			1: pcount = reg_prox_thr + 8'd1;
			default: pcount = 8'($urandom_range(0, 255));
		endcase
		return event_item(1'($urandom_range(0, 1)), $urandom_range(0, 99) < 80, light, pcount);
	endfunction

	function automatic logic [4:0] pick_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 5'd16;
		if (r < 18)
			return 5'($urandom_range(17, 31));
		return 5'($urandom_range(0, 16));
	endfunction

	task automatic test_reset_defaults();
		sensor_item_t noise;
		send_item(event_item(1'b0, 1'b0, 16'd0, 8'd0));
		send_item(event_item(1'b1, 1'b0, 16'd1234, 8'd255));
		// near latched: proximity is reported even without its flag
		send_item(event_item(1'b0, 1'b0, 16'd0, 8'd0));
		// lens zero and no zones loaded: lux reported as zero, no window
		send_item(event_item(1'b0, 1'b1, 16'hffff, 8'd7));
		noise = event_item(1'b1, 1'b1, 16'd100, 8'd9);
		noise.act = ACT_NONE;
		send_item(noise);
		send_item(event_item(1'b1, 1'b1, 16'd0, 8'd0));
		drain(30);
	endtask

	task automatic load_zone_tables();
		int hi;
		for (int i = 0; i < NZ; i++) begin
			send_item(load_item(ACT_LOAD_LOW, 4'(i), make_zone(12'(i * 64), 12'(i * 64 + 100))));
			hi = (i * 256 + 300 > 4095) ? 4095 : i * 256 + 300;
			send_item(load_item(ACT_LOAD_HIGH, 4'(i), make_zone(12'(i * 256), 12'(hi))));
		end
		drain(30);
	endtask

	task automatic test_range_switching();
		write_config(5'd16, 5'd16, 8'd128, 8'd1, 16'd1000);
		send_item(event_item(1'b0, 1'b1, 16'd500, 8'd0));
		send_item(event_item(1'b0, 1'b1, 16'd1000, 8'd0));
		send_item(event_item(1'b0, 1'b1, 16'hffff, 8'd0));
		send_item(event_item(1'b0, 1'b1, 16'd4095, 8'd0));
		send_item(event_item(1'b1, 1'b0, 16'd0, 8'd128));
		send_item(event_item(1'b1, 1'b0, 16'd0, 8'd129));
		send_item(event_item(1'b1, 1'b1, 16'd300, 8'd0));
		drain(30);
	endtask

	task automatic test_clamped_count();
		write_config(5'd20, 5'd31, 8'd0, 8'd255, 16'hffff);
		send_item(event_item(1'b0, 1'b1, 16'd0, 8'd0));
		send_item(event_item(1'b0, 1'b1, 16'd1000, 8'd0));
		send_item(event_item(1'b0, 1'b1, 16'hffff, 8'd0));
		send_item(event_item(1'b0, 1'b1, 16'd3900, 8'd0));
		drain(30);
	endtask

	task automatic test_empty_tables();
		write_config(5'd0, 5'd0, 8'd255, 8'd100, 16'hffff);
		send_item(event_item(1'b0, 1'b1, 16'd10, 8'd0));
		send_item(event_item(1'b1, 1'b1, 16'd50, 8'd255));
		drain(30);
	endtask

	task automatic test_random_traffic(input int items, input bit no_gaps);
		sensor_item_t it;
		logic [7:0] thr;
		logic [7:0] lens;
		logic [15:0] trig;
		logic [11:0] lo;
		int r;
		int sent;
		r = $urandom_range(0, 99);
		thr = (r < 10) ? 8'd0 : (r < 20) ? 8'd255 : 8'($urandom_range(0, 255));
		r = $urandom_range(0, 99);
		lens = (r < 10) ? 8'd0 : (r < 20) ? 8'd1 : (r < 30) ? 8'd255
			: 8'($urandom_range(1, 255));
		r = $urandom_range(0, 99);
		trig = (r < 15) ? 16'd0 : (r < 30) ? 16'hffff : (r < 70)
			? 16'($urandom_range(0, 4096)) : 16'($urandom_range(0, 65535));
		write_config(pick_count(), pick_count(), thr, lens, trig);
		steady = no_gaps;
		sent = 0;
		while (sent < items) begin
			r = $urandom_range(0, 99);
			if (r < 5) begin
				it = random_event();
				it.act = ACT_NONE;
				send_item(it);
			end else if (r < 20) begin
				lo = 12'($urandom_range(0, 4095));
				it = load_item($urandom_range(0, 1) ? ACT_LOAD_LOW : ACT_LOAD_HIGH,
					4'($urandom_range(0, 15)), $urandom_range(0, 1)
					? make_zone(lo, (lo > 3695) ? 12'd4095 : lo + 12'($urandom_range(0, 400)))
					: 24'($urandom_range(0, 24'hffffff)));
				send_item(it);
				sent++;
			end else begin
				send_item(random_event());
				sent++;
			end
		end
		drain(30);
		steady = 1'b0;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		load_zone_tables();
		test_range_switching();
		test_clamped_count();
		test_empty_tables();
		for (int p = 0; p < 6; p++)
			test_random_traffic(100, p == 3);
		drain(40);
		if (failures == 0 && expected_reports.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/lszr_pkg.sv
sv/lszr_ctrl.sv
sv/lszr_dp.sv
sv/light_sensor_zone_ranger_unit.sv
tb/light_sensor_zone_ranger_unit_tb.sv
